>>> hdl/ccr_pkg.sv
package ccr_pkg;

  localparam int RAW_BYTES_DEF   = 256;
  localparam int MAX_PAYLOAD_DEF = 254;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  target_slot;
    logic [7:0]  chunk_index;
    logic [7:0]  total_chunks;
    logic [7:0]  session_id;
    logic [31:0] chunk_word;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  ack_status;
    logic [7:0]  result_session;
    logic [7:0]  payload_len;
    logic [31:0] payload_word;
    logic [2:0]  word_bytes;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic [7:0]  node_slot;
    logic        node_is_hub;
    logic [10:0] config_frame_id;
    logic        handler_present;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_NODE_SLOT       = 2'd0,
    REG_NODE_IS_HUB     = 2'd1,
    REG_CONFIG_FRAME_ID = 2'd2,
    REG_HANDLER_PRESENT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACK_OVERFLOW   = 2'd0,
    ACK_TOO_SHORT  = 2'd1,
    ACK_BAD_LEN    = 2'd2,
    ACK_NO_HANDLER = 2'd3
  } ack_code_t;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_ACK  = 1'b1;
  localparam logic [3:0] FULL_FRAME_LEN = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD0,
    ST_CHK,
    ST_LOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic      load_frame;
    logic      eval;
    logic      rd;
    logic      chk_load;
    logic      ack_load;
    ack_code_t ack_code;
    logic      word_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ev_ovf;
    logic ev_done;
    logic chk_bad;
    logic handler;
    logic out_last;
  } dp_status_t;

endpackage

>>> hdl/config_chunk_reassembler_core.sv
// Channel  Signals                          Request moves
// -------  -------------------------------  ---------------------------------
// in       in_valid / in_ready / in_data    one received bus frame (in_t)
// out      out_valid / out_ready / out_data one payload word or ack (out_t)
// cfg      psel penable pwrite paddr pwdata four control registers at 4*i
//
// A frame is first registered, then filtered, matched and its chunk written into
// the single-port store. A completing chunk then has the length header read and
// checked, and each payload word takes a store read and an output load, plus
// any output stall.
// Reset clears the session and the control registers; the store is not
// cleared. in_ready stays low while a result is pending or being emitted.
module config_chunk_reassembler_core
  import ccr_pkg::*;
#(
  parameter int RAW_BYTES   = RAW_BYTES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  ccr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccr_datapath #(
    .RAW_BYTES   (RAW_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  ccr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

endmodule

>>> hdl/ccr_regs.sv
module ccr_regs
  import ccr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_NODE_SLOT:       cfg.node_slot       <= pwdata[7:0];
        REG_NODE_IS_HUB:     cfg.node_is_hub     <= pwdata[0];
        REG_CONFIG_FRAME_ID: cfg.config_frame_id <= pwdata[10:0];
        REG_HANDLER_PRESENT: cfg.handler_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NODE_SLOT:       prdata = {24'd0, cfg.node_slot};
      REG_NODE_IS_HUB:     prdata = {31'd0, cfg.node_is_hub};
      REG_CONFIG_FRAME_ID: prdata = {21'd0, cfg.config_frame_id};
      REG_HANDLER_PRESENT: prdata = {31'd0, cfg.handler_present};
      default:             prdata = '0;
    endcase
  end

endmodule

>>> hdl/ccr_datapath.sv
module ccr_datapath
  import ccr_pkg::*;
#(
  parameter int RAW_BYTES   = RAW_BYTES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  in_t        in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_t       out_data
);

  localparam int STORE_WORDS = RAW_BYTES / 4;
  localparam int AW  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int PW  = $clog2(STORE_WORDS + 1);
  localparam int PLW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD + 1) : 1;

  logic [31:0] store [STORE_WORDS];

  in_t         fr;
  logic        sess_active;
  logic [7:0]  sess_tag;
  logic [7:0]  sess_expected;
  logic [7:0]  sess_received;
  logic [31:0] rdata;
  logic [15:0] hi;
  logic [PW-1:0]  rd_ptr;
  logic [PLW-1:0] plen;
  logic [PLW-1:0] rem;

  logic        ign, restart, match, ovf, done;
  logic        act_e;
  logic [7:0]  tag_e, exp_e, rcv_e, rcv_n;
  logic [10:0] raw_len;
  logic [15:0] hdr_len;
  logic        chk_bad;
  logic [2:0]  cnt;
  logic        last;
  logic [31:0] word_raw, word_m;

  // frame filter and session match, evaluated on the registered frame
  always_comb begin
    ign = (fr.frame_id != cfg.config_frame_id) || (fr.frame_len < FULL_FRAME_LEN) ||
          cfg.node_is_hub || (fr.target_slot != cfg.node_slot) ||
          (cfg.node_slot == 8'd0) || (fr.total_chunks == 8'd0);
    restart = (fr.chunk_index == 8'd0);
    act_e   = restart ? 1'b1 : sess_active;
    tag_e   = restart ? fr.session_id : sess_tag;
    exp_e   = restart ? fr.total_chunks : sess_expected;
    rcv_e   = restart ? 8'd0 : sess_received;
    match   = !ign && act_e && (tag_e == fr.session_id) &&
              (exp_e == fr.total_chunks) && (fr.chunk_index == rcv_e);
    ovf     = match && ({1'b0, fr.chunk_index} >= 9'(STORE_WORDS));
    rcv_n   = rcv_e + 8'd1;
    done    = match && !ovf && (rcv_n >= exp_e);
  end

  // header check: store word 0 sits in rdata during the check cycle
  always_comb begin
    hdr_len = rdata[15:0];
    raw_len = {1'b0, fr.chunk_index, 2'b00} + 11'd4;
    chk_bad = (hdr_len == 16'd0) || (hdr_len > 16'(MAX_PAYLOAD)) ||
              (({1'b0, hdr_len} + 17'd2) > 17'(raw_len));
  end

  // payload word i = upper half of store[i] and lower half of store[i+1]
  always_comb begin
    last     = 32'(rem) <= 32'd4;
    cnt      = last ? 3'(rem) : 3'd4;
    word_raw = {rdata[15:0], hi};
    for (int b = 0; b < 4; b++) begin
      word_m[8*b +: 8] = (b < int'(cnt)) ? word_raw[8*b +: 8] : 8'd0;
    end
  end

  assign status = '{ev_ovf:   ovf,
                    ev_done:  done,
                    chk_bad:  chk_bad,
                    handler:  cfg.handler_present,
                    out_last: out_data.last_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      sess_active   <= 1'b0;
      sess_tag      <= '0;
      sess_expected <= '0;
      sess_received <= '0;
    end else if (cmd.eval && !ign) begin
      sess_active   <= act_e;
      sess_tag      <= tag_e;
      sess_expected <= exp_e;
      sess_received <= rcv_e;
      if (match) begin
        if (ovf) begin
          sess_active <= 1'b0;
        end else begin
          sess_received <= rcv_n;
          if (done) sess_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && match && !ovf) begin
      store[fr.chunk_index[AW-1:0]] <= fr.chunk_word;
    end
    if (cmd.rd && (32'(rd_ptr) < STORE_WORDS)) begin
      rdata <= store[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) fr <= in_data;
    if (cmd.eval) rd_ptr <= '0;
    else if (cmd.rd) rd_ptr <= rd_ptr + PW'(1);
    if (cmd.chk_load) begin
      plen <= hdr_len[PLW-1:0];
      rem  <= hdr_len[PLW-1:0];
      hi   <= rdata[31:16];
    end
    if (cmd.word_load) begin
      hi  <= rdata[31:16];
      rem <= rem - PLW'(cnt);
      out_data.result_kind    <= KIND_WORD;
      out_data.ack_status     <= '0;
      out_data.result_session <= fr.session_id;
      out_data.payload_len    <= 8'(plen);
      out_data.payload_word   <= word_m;
      out_data.word_bytes     <= cnt;
      out_data.last_word      <= last;
    end else if (cmd.ack_load) begin
      out_data.result_kind    <= KIND_ACK;
      out_data.ack_status     <= cmd.ack_code;
      out_data.result_session <= fr.session_id;
      out_data.payload_len    <= '0;
      out_data.payload_word   <= '0;
      out_data.word_bytes     <= '0;
      out_data.last_word      <= 1'b1;
    end
  end

endmodule

>>> hdl/ccr_ctrl.sv
module ccr_ctrl
  import ccr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ack_code = ACK_OVERFLOW;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_frame = 1'b1;
          state_next     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.ev_ovf) begin
          cmd.ack_load = 1'b1;
          cmd.ack_code = ACK_OVERFLOW;
          state_next   = ST_OUT;
        end else if (status.ev_done) begin
          state_next = ST_RD0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RD0: begin
        cmd.rd     = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (status.chk_bad) begin
          cmd.ack_load = 1'b1;
          cmd.ack_code = ACK_BAD_LEN;
          state_next   = ST_OUT;
        end else if (!status.handler) begin
          cmd.ack_load = 1'b1;
          cmd.ack_code = ACK_NO_HANDLER;
          state_next   = ST_OUT;
        end else begin
          cmd.chk_load = 1'b1;
          cmd.rd       = 1'b1;
          state_next   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.word_load = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.out_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd     = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> bench/tb_config_chunk_reassembler_core.sv
module tb_config_chunk_reassembler_core;
  import ccr_pkg::*;

  localparam int CYCLE_LIMIT   = 6000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_FRAMES = 240;
  localparam int STORE_WORDS   = RAW_BYTES_DEF / 4;
  localparam int SW_AW         = $clog2(STORE_WORDS);
  localparam int LONG_HOLD     = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  config_chunk_reassembler_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow copy of the node registers and the session
  logic [7:0]  cfg_slot    = '0;
  logic        cfg_hub     = 1'b0;
  logic [10:0] cfg_fid     = '0;
  logic        cfg_handler = 1'b0;
  bit          sess_open   = 1'b0;
  logic [7:0]  sess_tag    = '0;
  logic [7:0]  sess_total  = '0;
  logic [7:0]  sess_count  = '0;
  logic [31:0] chunk_mem [STORE_WORDS];

  out_t step_out [64];
  int   step_cnt;
  out_t pending_results [$];

  int errors       = 0;
  int results_seen = 0;
  int cycles       = 0;
  int fed          = 0;

  typedef struct {
    in_t  frame;
    bit   typed;
    int   n;
    out_t want;
  } row_t;

  row_t dir_rows [$];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic in_t mk_frame(input logic [10:0] fid, input logic [3:0] len,
                                   input logic [7:0] slot, input logic [7:0] idx,
                                   input logic [7:0] total, input logic [7:0] tag,
                                   input logic [31:0] word);
    in_t f;
    f.frame_id     = fid;
    f.frame_len    = len;
    f.target_slot  = slot;
    f.chunk_index  = idx;
    f.total_chunks = total;
    f.session_id   = tag;
    f.chunk_word   = word;
    return f;
  endfunction

  function automatic out_t ack_of(input ack_code_t code, input logic [7:0] tag);
    out_t r;
    r                = '0;
    r.result_kind    = KIND_ACK;
    r.ack_status     = code;
    r.result_session = tag;
    r.last_word      = 1'b1;
    return r;
  endfunction

  function automatic out_t word_of(input logic [7:0] tag, input logic [7:0] plen,
                                   input logic [31:0] w, input logic [2:0] nbytes,
                                   input logic last);
    out_t r;
    r                = '0;
    r.result_kind    = KIND_WORD;
    r.result_session = tag;
    r.payload_len    = plen;
    r.payload_word   = w;
    r.word_bytes     = nbytes;
    r.last_word      = last;
    return r;
  endfunction

  function automatic logic [7:0] stored_byte(input int unsigned k);
    logic [31:0] w;
    w = chunk_mem[k[SW_AW+1:2]];
    return w[8 * (k & 3) +: 8];
  endfunction

  // advance the shadow session by one accepted frame; results go to step_out
  task automatic reassemble(input in_t f);
    int unsigned off;
    int unsigned rlen;
    int unsigned plen;
    int unsigned nwords;
    int unsigned cnt;
    logic [31:0] w;
    step_cnt = 0;
    if (f.frame_id != cfg_fid || f.frame_len < FULL_FRAME_LEN || cfg_hub) return;
    if (f.target_slot != cfg_slot || cfg_slot == 8'd0 || f.total_chunks == 8'd0) return;
    if (f.chunk_index == 8'd0) begin
      sess_open  = 1'b1;
      sess_tag   = f.session_id;
      sess_total = f.total_chunks;
      sess_count = '0;
    end
    if (!sess_open || f.session_id != sess_tag || f.total_chunks != sess_total ||
        f.chunk_index != sess_count) return;
    off = 4 * f.chunk_index;
    if (off + 4 > RAW_BYTES_DEF) begin
      sess_open   = 1'b0;
      step_out[0] = ack_of(ACK_OVERFLOW, f.session_id);
      step_cnt    = 1;
      return;
    end
    chunk_mem[f.chunk_index[SW_AW-1:0]] = f.chunk_word;
    rlen       = off + 4;
    sess_count = sess_count + 8'd1;
    if (sess_count < sess_total) return;
    sess_open = 1'b0;
    step_cnt  = 1;
    plen      = 32'({stored_byte(1), stored_byte(0)});
    if (rlen < 2) begin
      step_out[0] = ack_of(ACK_TOO_SHORT, f.session_id);
    end else if (plen == 0 || plen > MAX_PAYLOAD_DEF || plen + 2 > rlen) begin
      step_out[0] = ack_of(ACK_BAD_LEN, f.session_id);
    end else if (!cfg_handler) begin
      step_out[0] = ack_of(ACK_NO_HANDLER, f.session_id);
    end else begin
      nwords = (plen + 3) / 4;
      for (int unsigned i = 0; i < nwords; i++) begin
        cnt = plen - 4 * i;
        if (cnt > 4) cnt = 4;
        w = '0;
        for (int unsigned b = 0; b < cnt; b++)
          w[8 * b +: 8] = stored_byte(2 + 4 * i + b);
        step_out[i] = word_of(f.session_id, plen[7:0], w, cnt[2:0], i + 1 == nwords);
      end
      step_cnt = nwords;
    end
  endtask

  // hold the request until accepted; the random gap comes first
  task automatic offer(input in_t f);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 70) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_checked(input in_t f);
    offer(f);
    reassemble(f);
    for (int i = 0; i < step_cnt; i++) pending_results.push_back(step_out[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_NODE_SLOT:       cfg_slot    = val[7:0];
      REG_NODE_IS_HUB:     cfg_hub     = val[0];
      REG_CONFIG_FRAME_ID: cfg_fid     = val[10:0];
      REG_HANDLER_PRESENT: cfg_handler = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] slot, input logic hub,
                            input logic [10:0] fid, input logic handler);
    settle();
    apply_regs: begin
      apb_write(REG_NODE_SLOT, {24'd0, slot});
      apb_write(REG_NODE_IS_HUB, {31'd0, hub});
      apb_write(REG_CONFIG_FRAME_ID, {21'd0, fid});
      apb_write(REG_HANDLER_PRESENT, {31'd0, handler});
    end
  endtask

  task automatic add_row(input in_t f, input bit typed, input int n, input out_t want);
    row_t r;
    r.frame = f;
    r.typed = typed;
    r.n     = n;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic walk_rows(input int from, input int to);
    for (int i = from; i <= to; i++) begin
      offer(dir_rows[i].frame);
      reassemble(dir_rows[i].frame);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].n != 0) pending_results.push_back(dir_rows[i].want);
      end else begin
        for (int k = 0; k < step_cnt; k++) pending_results.push_back(step_out[k]);
      end
    end
  endtask

  // corrupt one field of a frame, or replace it with noise
  function automatic in_t mangle(input in_t f);
    in_t g;
    g = f;
    case ($urandom_range(0, 7))
      0: g.frame_id    = f.frame_id ^ 11'($urandom_range(1, 2047));
      1: g.frame_len   = 4'($urandom_range(0, 7));
      2: g.target_slot = f.target_slot ^ 8'($urandom_range(1, 255));
      3: g.total_chunks = '0;
      4: g.session_id  = f.session_id ^ 8'($urandom_range(1, 255));
      5: g.total_chunks = f.total_chunks ^ 8'($urandom_range(1, 255));
      6: g.chunk_index = 8'($urandom_range(0, 255));
      default: begin
        g.frame_id     = 11'($urandom);
        g.frame_len    = 4'($urandom);
        g.target_slot  = 8'($urandom);
        g.chunk_index  = 8'($urandom);
        g.total_chunks = 8'($urandom);
        g.session_id   = 8'($urandom);
        g.chunk_word   = $urandom;
      end
    endcase
    return g;
  endfunction

  // one transfer of random content; full_len sends the largest payload
  task automatic random_transfer(input int total, input bit full_len);
    in_t f;
    int plen;
    int maxlen;
    int nsend;
    int r;
    logic [7:0] tag;
    tag    = 8'($urandom_range(0, 255));
    maxlen = (4 * total - 2 < MAX_PAYLOAD_DEF) ? 4 * total - 2 : MAX_PAYLOAD_DEF;
    r      = $urandom_range(0, 99);
    if (full_len) plen = MAX_PAYLOAD_DEF;
    else if (r < 86) plen = $urandom_range(1, maxlen);
    else if (r < 91) plen = 0;
    else if (r < 95) plen = $urandom_range(MAX_PAYLOAD_DEF + 1, 65535);
    else plen = 4 * total - 1;
    nsend = (total > STORE_WORDS) ? STORE_WORDS + 1 : total;
    if (!full_len && $urandom_range(0, 99) < 6) nsend = $urandom_range(1, nsend);
    for (int k = 0; k < nsend; k++) begin
      f.frame_id     = cfg_fid;
      f.frame_len    = ($urandom_range(0, 99) < 70) ? FULL_FRAME_LEN :
                       4'($urandom_range(9, 15));
      f.target_slot  = cfg_slot;
      f.chunk_index  = 8'(k);
      f.total_chunks = 8'(total);
      f.session_id   = tag;
      f.chunk_word   = $urandom;
      if (k == 0) f.chunk_word[15:0] = plen[15:0];
      if ($urandom_range(0, 99) < 12) begin
        send_checked(mangle(f));
        fed++;
      end
      send_checked(f);
      fed++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_kind !== want.result_kind)
          flag_mismatch($sformatf("result_kind %b want %b", out_data.result_kind,
                                  want.result_kind));
        if (out_data.ack_status !== want.ack_status)
          flag_mismatch($sformatf("ack_status %0d want %0d", out_data.ack_status,
                                  want.ack_status));
        if (out_data.result_session !== want.result_session)
          flag_mismatch($sformatf("result_session %h want %h", out_data.result_session,
                                  want.result_session));
        if (out_data.payload_len !== want.payload_len)
          flag_mismatch($sformatf("payload_len %0d want %0d", out_data.payload_len,
                                  want.payload_len));
        if (out_data.payload_word !== want.payload_word)
          flag_mismatch($sformatf("payload_word %h want %h", out_data.payload_word,
                                  want.payload_word));
        if (out_data.word_bytes !== want.word_bytes)
          flag_mismatch($sformatf("word_bytes %0d want %0d", out_data.word_bytes,
                                  want.word_bytes));
        if (out_data.last_word !== want.last_word)
          flag_mismatch($sformatf("last_word %b want %b", out_data.last_word,
                                  want.last_word));
      end
    end
  end

  // receiver: runs of ready, random stalls, and one long hold-off
  initial begin : sink
    int r;
    int n;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_seen >= 16) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (r < 50) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (r < 85) begin
        n = $urandom_range(2, 20);
        repeat (n) begin
          out_ready <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end
      end else if (r < 97) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int seq;
    int r;
    int t;
    logic [7:0]  slot;
    logic        hub;
    logic [10:0] fid;
    logic        handler;
    in_t f;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    // after reset: slot 0 disables reception
    add_row(mk_frame(11'h000, 4'd8, 8'h00, 8'd0, 8'd1, 8'h00, 32'h0000_0004), 1, 0, '0);
    // node slot FF, id 7FF, handler present
    add_row(mk_frame(11'h7FE, 4'd8, 8'hFF, 8'd0, 8'd1, 8'h10, 32'h0000_0002), 1, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd7, 8'hFF, 8'd0, 8'd1, 8'h10, 32'h0000_0002), 1, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'h7F, 8'd0, 8'd1, 8'h10, 32'h0000_0002), 1, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd0, 8'h10, 32'h0000_0002), 1, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'hA5, 32'hBEEF_0002), 1, 1,
            word_of(8'hA5, 8'd2, 32'h0000_BEEF, 3'd2, 1'b1));
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'h00, 32'h1234_0000), 1, 1,
            ack_of(ACK_BAD_LEN, 8'h00));
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'h5A, 32'h0000_0003), 1, 1,
            ack_of(ACK_BAD_LEN, 8'h5A));
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'hFF, 32'hFFFF_FFFF), 1, 1,
            ack_of(ACK_BAD_LEN, 8'hFF));
    add_row(mk_frame(11'h7FF, 4'd15, 8'hFF, 8'd0, 8'd1, 8'h11, 32'hFFFF_0001), 1, 1,
            word_of(8'h11, 8'd1, 32'h0000_00FF, 3'd1, 1'b1));
    // chunk with no session open
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd1, 8'd3, 8'h3C, 32'h0000_0000), 1, 0, '0);
    // three-chunk transfer with stray chunks in between
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd3, 8'h3C, 32'h4433_000A), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd1, 8'd3, 8'h3D, 32'hDEAD_BEEF), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd2, 8'd3, 8'h3C, 32'hDEAD_BEEF), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd1, 8'd3, 8'h3C, 32'h8877_6655), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd2, 8'd4, 8'h3C, 32'hDEAD_BEEF), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd2, 8'd3, 8'h3C, 32'hCCBB_AA99), 0, 0, '0);
    // restart in the middle of a transfer
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd2, 8'h01, 32'h0000_0004), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'h02, 32'h0077_0001), 0, 0, '0);
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd255, 8'd255, 8'h80, 32'h0000_0000), 0, 0, '0);
    // no handler
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'h42, 32'h0000_0001), 1, 1,
            ack_of(ACK_NO_HANDLER, 8'h42));
    // hub ignores everything
    add_row(mk_frame(11'h7FF, 4'd8, 8'hFF, 8'd0, 8'd1, 8'h43, 32'h0000_0001), 1, 0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    walk_rows(0, 0);
    set_config(8'hFF, 1'b0, 11'h7FF, 1'b1);
    walk_rows(1, 19);
    set_config(8'hFF, 1'b0, 11'h7FF, 1'b0);
    walk_rows(20, 20);
    set_config(8'hFF, 1'b1, 11'h7FF, 1'b1);
    walk_rows(21, 21);

    seq = 0;
    while (fed < RANDOM_FRAMES) begin
      r = $urandom_range(0, 99);
      if (r < 8) slot = 8'd0;
      else if (r < 18) slot = 8'd255;
      else if (r < 28) slot = 8'd1;
      else slot = 8'($urandom_range(1, 254));
      hub = ($urandom_range(0, 99) < 8);
      r = $urandom_range(0, 99);
      if (r < 10) fid = '0;
      else if (r < 20) fid = 11'h7FF;
      else fid = 11'($urandom);
      handler = ($urandom_range(0, 99) < 85);
      set_config(slot, hub, fid, handler);
      if (slot != 8'd0 && !hub) begin
        repeat ($urandom_range(2, 5)) begin
          if (seq == 2) random_transfer(STORE_WORDS, 1'b1);
          else if (seq == 6) random_transfer($urandom_range(STORE_WORDS + 1, 255), 1'b0);
          else begin
            t = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            random_transfer(t, 1'b0);
          end
          seq++;
        end
      end else begin
        // ignored by this node
        repeat (4) begin
          f = mk_frame(cfg_fid, FULL_FRAME_LEN, 8'($urandom), 8'($urandom_range(0, 3)),
                       8'($urandom_range(1, 4)), 8'($urandom), $urandom);
          send_checked(f);
          fed++;
        end
      end
    end

    settle();
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
